/* hw/rtl/longest_silence_run_finder_macros.svh */
// ----------------------------------------------------------------------------
// longest_silence_run_finder_macros
// Assertion macros shared by the longest silence run finder modules.
// ----------------------------------------------------------------------------
`ifndef LONGEST_SILENCE_RUN_FINDER_MACROS_SVH
`define LONGEST_SILENCE_RUN_FINDER_MACROS_SVH

// check on every clock edge outside reset
`define LSRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check on every clock edge, reset included
`define LSRF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/lsrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrf_pkg
// Types, register map and constants of the longest silence run finder.
// ----------------------------------------------------------------------------
package lsrf_pkg;

    localparam int unsigned MAX_WINDOW_FRAMES = 262144;
    localparam int unsigned COUNT_W           = 18;
    localparam int unsigned SAMPLE_W          = 16;
    localparam int unsigned CFG_ADDR_W        = 4;
    localparam int unsigned CFG_DATA_W        = 32;

    localparam longint unsigned COUNT_MAX   = (64'd1 << COUNT_W) - 64'd1;
    localparam longint unsigned CAP_RAW     = (MAX_WINDOW_FRAMES == 0) ? 64'd0 :
                                              64'(MAX_WINDOW_FRAMES) - 64'd1;
    localparam logic [COUNT_W-1:0] COUNT_CAP = (CAP_RAW > COUNT_MAX) ?
                                               COUNT_W'(COUNT_MAX) : COUNT_W'(CAP_RAW);

    localparam logic [1:0] REG_SILENCE_BOUND  = 2'd0;
    localparam logic [1:0] REG_FADE_LIMIT     = 2'd1;
    localparam logic [1:0] REG_USABLE_LIMIT   = 2'd2;
    localparam logic [1:0] REG_BACKOFF_FRAMES = 2'd3;

    localparam logic [SAMPLE_W-1:0] SILENCE_BOUND_RST  = 16'd9;
    localparam logic [COUNT_W-1:0]  FADE_LIMIT_RST     = 18'd50;
    localparam logic [COUNT_W-1:0]  USABLE_LIMIT_RST   = 18'd8;
    localparam logic [COUNT_W-1:0]  BACKOFF_FRAMES_RST = 18'd1400;

    typedef struct packed {
        logic [SAMPLE_W-1:0] silence_bound;
        logic [COUNT_W-1:0]  fade_limit;
        logic [COUNT_W-1:0]  usable_limit;
        logic [COUNT_W-1:0]  backoff_frames;
    } lsrf_cfg_t;

    typedef struct packed {
        logic               load;
        logic [COUNT_W-1:0] start;
        logic [COUNT_W-1:0] length;
    } lsrf_best_t;

endpackage

/* hw/rtl/lsrf_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrf_cfg_regs
// APB register file holding the silence bound, limits and backoff.
// ----------------------------------------------------------------------------
module lsrf_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lsrf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [lsrf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lsrf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output lsrf_pkg::lsrf_cfg_t                 cfg
);
    import lsrf_pkg::*;

    lsrf_cfg_t  cfg_reg;
    lsrf_cfg_t  cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_SILENCE_BOUND:  cfg_next.silence_bound  = pwdata[SAMPLE_W-1:0];
                REG_FADE_LIMIT:     cfg_next.fade_limit     = pwdata[COUNT_W-1:0];
                REG_USABLE_LIMIT:   cfg_next.usable_limit   = pwdata[COUNT_W-1:0];
                REG_BACKOFF_FRAMES: cfg_next.backoff_frames = pwdata[COUNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SILENCE_BOUND:  prdata = CFG_DATA_W'(cfg_reg.silence_bound);
            REG_FADE_LIMIT:     prdata = CFG_DATA_W'(cfg_reg.fade_limit);
            REG_USABLE_LIMIT:   prdata = CFG_DATA_W'(cfg_reg.usable_limit);
            REG_BACKOFF_FRAMES: prdata = CFG_DATA_W'(cfg_reg.backoff_frames);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.silence_bound  <= SILENCE_BOUND_RST;
            cfg_reg.fade_limit     <= FADE_LIMIT_RST;
            cfg_reg.usable_limit   <= USABLE_LIMIT_RST;
            cfg_reg.backoff_frames <= BACKOFF_FRAMES_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/lsrf_run_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrf_run_tracker
// Input register and per-sample silent run tracking over one window.
// ----------------------------------------------------------------------------
module lsrf_run_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lsrf_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_last_of_window,
    input  logic [lsrf_pkg::SAMPLE_W-1:0]       silence_bound,
    input  logic                                out_free,
    output lsrf_pkg::lsrf_best_t                best_o
);
    import lsrf_pkg::*;

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;

    logic [COUNT_W-1:0] frame_index_reg, frame_index_next;
    logic               prev_silent_reg, prev_silent_next;
    logic [COUNT_W-1:0] run_start_reg, run_start_next;
    logic [COUNT_W-1:0] run_length_reg, run_length_next;
    logic [COUNT_W-1:0] best_start_reg, best_start_next;
    logic [COUNT_W-1:0] best_length_reg, best_length_next;

    logic                     advance;
    logic signed [SAMPLE_W:0] sample_ext;
    logic signed [SAMPLE_W:0] bound_pos;
    logic signed [SAMPLE_W:0] bound_neg;
    logic                     silent;
    logic [COUNT_W-1:0]       run_start_upd, run_length_upd;
    logic [COUNT_W-1:0]       best_start_upd, best_length_upd;
    logic                     final_take;

    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    assign sample_ext = {in_sample_reg[SAMPLE_W-1], in_sample_reg};
    assign bound_pos  = signed'({1'b0, silence_bound});
    assign bound_neg  = -bound_pos;
    assign silent     = (sample_ext < bound_pos) && (sample_ext > bound_neg);

    always_comb begin
        run_start_upd   = run_start_reg;
        run_length_upd  = run_length_reg;
        best_start_upd  = best_start_reg;
        best_length_upd = best_length_reg;
        case ({silent, prev_silent_reg})
            2'b10: begin
                run_start_upd  = frame_index_reg;
                run_length_upd = '0;
            end
            2'b11: begin
                if (run_length_reg < COUNT_CAP) begin
                    run_length_upd = run_length_reg + COUNT_W'(1);
                end
            end
            2'b00: begin
                run_length_upd = '0;
            end
            default: begin
                if (run_length_reg > best_length_reg) begin
                    best_start_upd  = run_start_reg;
                    best_length_upd = run_length_reg;
                end
                run_start_upd  = '0;
                run_length_upd = '0;
            end
        endcase
    end

    assign final_take    = run_length_upd > best_length_upd;
    assign best_o.load   = advance && in_last_reg;
    assign best_o.start  = final_take ? run_start_upd : best_start_upd;
    assign best_o.length = final_take ? run_length_upd : best_length_upd;

    always_comb begin
        frame_index_next = frame_index_reg;
        prev_silent_next = prev_silent_reg;
        run_start_next   = run_start_reg;
        run_length_next  = run_length_reg;
        best_start_next  = best_start_reg;
        best_length_next = best_length_reg;
        if (advance) begin
            if (in_last_reg) begin
                frame_index_next = '0;
                prev_silent_next = 1'b0;
                run_start_next   = '0;
                run_length_next  = '0;
                best_start_next  = '0;
                best_length_next = '0;
            end else begin
                prev_silent_next = silent;
                run_start_next   = run_start_upd;
                run_length_next  = run_length_upd;
                best_start_next  = best_start_upd;
                best_length_next = best_length_upd;
                if (frame_index_reg < COUNT_CAP) begin
                    frame_index_next = frame_index_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
            in_last_reg   <= s_last_of_window;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            frame_index_reg <= '0;
            prev_silent_reg <= 1'b0;
            run_start_reg   <= '0;
            run_length_reg  <= '0;
            best_start_reg  <= '0;
            best_length_reg <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            frame_index_reg <= frame_index_next;
            prev_silent_reg <= prev_silent_next;
            run_start_reg   <= run_start_next;
            run_length_reg  <= run_length_next;
            best_start_reg  <= best_start_next;
            best_length_reg <= best_length_next;
        end
    end

`include "longest_silence_run_finder_macros.svh"

    `LSRF_ASSERT(a_run_zero_after_noise, !prev_silent_reg |-> (run_length_reg == '0), "run length nonzero outside a silent run")
    `LSRF_ASSERT(a_frame_capped, frame_index_reg <= COUNT_CAP, "frame index beyond cap")
    `LSRF_ASSERT(a_window_cleared, (advance && in_last_reg) |=> (frame_index_reg == '0 && best_length_reg == '0 && !prev_silent_reg), "window state not cleared after last word")

endmodule

/* hw/rtl/lsrf_result_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrf_result_stage
// Cut point and flag evaluation with the output register.
// ----------------------------------------------------------------------------
module lsrf_result_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lsrf_pkg::lsrf_cfg_t             cfg,
    input  lsrf_pkg::lsrf_best_t            best_i,
    output logic                            out_free,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lsrf_pkg::COUNT_W-1:0]    m_best_start,
    output logic [lsrf_pkg::COUNT_W-1:0]    m_best_length,
    output logic                            m_needs_fade,
    output logic                            m_silence_usable,
    output logic [lsrf_pkg::COUNT_W-1:0]    m_cut_frame
);
    import lsrf_pkg::*;

    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] start_reg, length_reg, cut_reg;
    logic               fade_reg, usable_reg;

    logic [COUNT_W-1:0] back;
    logic [COUNT_W:0]   cut_sum;
    logic [COUNT_W-1:0] cut;

    assign back    = (best_i.length < cfg.backoff_frames) ? best_i.length : cfg.backoff_frames;
    assign cut_sum = {1'b0, best_i.start} + {1'b0, best_i.length} - {1'b0, back};
    assign cut     = cut_sum[COUNT_W] ? '1 : cut_sum[COUNT_W-1:0];

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (best_i.load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (best_i.load) begin
            start_reg  <= best_i.start;
            length_reg <= best_i.length;
            cut_reg    <= cut;
            fade_reg   <= (best_i.length <= cfg.fade_limit);
            usable_reg <= (best_i.length > cfg.usable_limit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_best_start     = start_reg;
    assign m_best_length    = length_reg;
    assign m_needs_fade     = fade_reg;
    assign m_silence_usable = usable_reg;
    assign m_cut_frame      = cut_reg;

`include "longest_silence_run_finder_macros.svh"

    `LSRF_ASSERT(a_no_overwrite, best_i.load |-> (!out_valid_reg || m_ready), "result overwritten before it was taken")
    `LSRF_ASSERT(a_cut_not_before_start, out_valid_reg |-> (cut_reg >= start_reg), "cut frame ahead of run start")
    `LSRF_ASSERT(a_empty_run_cut, (out_valid_reg && length_reg == '0) |-> (cut_reg == start_reg), "cut frame moved for empty run")

endmodule

/* hw/rtl/longest_silence_run_finder.sv */
`timescale 1ns / 1ps
// Path: a word accepted on s_ is held in the input register; when it ends a window, its
//   result is taken into the output register, once that is free, and shows on m_.
// Throughput: one word per cycle; only a pending result waiting on m_ready stalls s_.
// Reset (aresetn low, synchronous): clears window state and valid flags, loads register defaults.
// ----------------------------------------------------------------------------
// longest_silence_run_finder
// Finds the longest near-silent run in a window of samples and its cut point.
// ----------------------------------------------------------------------------
module longest_silence_run_finder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsrf_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [lsrf_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [lsrf_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [lsrf_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_last_of_window,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lsrf_pkg::COUNT_W-1:0]         m_best_start,
    output logic [lsrf_pkg::COUNT_W-1:0]         m_best_length,
    output logic                                 m_needs_fade,
    output logic                                 m_silence_usable,
    output logic [lsrf_pkg::COUNT_W-1:0]         m_cut_frame
);
    import lsrf_pkg::*;

    lsrf_cfg_t  cfg;
    lsrf_best_t best;
    logic       out_free;

    lsrf_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsrf_run_tracker u_run_tracker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_last_of_window (s_last_of_window),
        .silence_bound    (cfg.silence_bound),
        .out_free         (out_free),
        .best_o           (best)
    );

    lsrf_result_stage u_result_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .best_i           (best),
        .out_free         (out_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_best_start     (m_best_start),
        .m_best_length    (m_best_length),
        .m_needs_fade     (m_needs_fade),
        .m_silence_usable (m_silence_usable),
        .m_cut_frame      (m_cut_frame)
    );

endmodule
